/* design/svsu_pkg.sv */
// Shared types and constants for the staggered velocity stencil update unit.
package svsu_pkg;
    localparam int MAX_HALF_ORDER_D = 4;
    localparam int FRAC_BITS_D      = 16;
    localparam int DATA_WIDTH_D     = 32;
    localparam int NUM_COEF         = 4;
    localparam int GHOST_DEPTH      = 3;

    localparam logic [2:0] REG_HALF_ORDER   = 3'd0;
    localparam logic [2:0] REG_COEF_0       = 3'd1;
    localparam logic [2:0] REG_COEF_3       = 3'd4;
    localparam logic [2:0] REG_LEFT_MIRROR  = 3'd5;
    localparam logic [2:0] REG_RIGHT_MIRROR = 3'd6;

    localparam logic [1:0] KIND_INTERIOR = 2'd0;
    localparam logic [1:0] KIND_LEFT     = 2'd1;
    localparam logic [1:0] KIND_RIGHT    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GRAD, ST_T1, ST_T2, ST_INNER, ST_FINAL, ST_EMIT, ST_GHOST
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture input item, shift window
        logic       clr_acc;
        logic       grad_step; // one stencil term
        logic [1:0] grad_k;
        logic       do_t1;
        logic       do_t2;
        logic       do_inner;
        logic       do_final;  // final product, update head/tail
        logic       ghost_sel; // 0 interior, 1 ghost from head/tail
        logic       ghost_right;
        logic [1:0] ghost_off;
        logic       clr_line;
    } t_cmd;
endpackage

/* design/svsu_datapath.sv */
// Datapath: pressure window, multiply unit, saturation and ghost stores.
module svsu_datapath #(
    parameter int MAX_HALF_ORDER = svsu_pkg::MAX_HALF_ORDER_D,
    parameter int FRAC_BITS      = svsu_pkg::FRAC_BITS_D,
    parameter int DATA_WIDTH     = svsu_pkg::DATA_WIDTH_D
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  svsu_pkg::t_cmd       i_cmd,
    input  logic [2:0]           i_h,
    input  logic signed [31:0]   i_coef [svsu_pkg::NUM_COEF],
    input  logic signed [31:0]   i_p_lead,
    input  logic signed [31:0]   i_v_old,
    input  logic signed [31:0]   i_buoy_here,
    input  logic signed [31:0]   i_buoy_next,
    input  logic signed [31:0]   i_damp_in,
    input  logic signed [31:0]   i_damp_out,
    output logic signed [31:0]   o_v,
    output logic                 o_ovf
);
    import svsu_pkg::*;
    localparam int WIN = 2 * MAX_HALF_ORDER;
    localparam int S   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic signed [63:0] HI = (64'sd1 <<< (S - 1)) - 64'sd1;
    localparam logic signed [63:0] LO = -HI - 64'sd1;

    logic signed [31:0] r_win [WIN];
    logic signed [31:0] r_v_old, r_damp_in, r_damp_out;
    logic signed [32:0] r_hb;
    logic signed [63:0] r_acc, r_t1, r_t2;
    logic signed [31:0] r_grad, r_inner;
    logic               r_ovf;
    logic signed [31:0] r_head [GHOST_DEPTH];
    logic signed [31:0] r_tail [GHOST_DEPTH];
    logic [1:0]         r_pts;
    logic signed [31:0] r_out;
    logic               r_out_ovf;

    function automatic logic signed [31:0] sat(input logic signed [63:0] x,
                                               output logic f);
        f = 1'b0;
        if (x > HI) begin f = 1'b1; return HI[31:0]; end
        if (x < LO) begin f = 1'b1; return LO[31:0]; end
        return x[31:0];
    endfunction

    // operand select for the shared multiplier
    logic [3:0]         h_eff;
    logic [3:0]         idx_a, idx_b;
    logic signed [32:0] d;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod, prod_sh;
    logic signed [31:0] s_val;
    logic               s_f;

    always_comb begin
        // order 0 acts as 1, larger orders stop at MAX_HALF_ORDER
        h_eff = (i_h == 3'd0) ? 4'd1 :
                (4'(i_h) > 4'(MAX_HALF_ORDER)) ? 4'(MAX_HALF_ORDER) : 4'(i_h);
        idx_a = h_eff - 4'(i_cmd.grad_k) - 4'd1;
        idx_b = h_eff + 4'(i_cmd.grad_k);
        d = 33'(r_win[idx_a[$clog2(WIN)-1:0]]) - 33'(r_win[idx_b[$clog2(WIN)-1:0]]);
        ma = d;
        mb = 33'(i_coef[i_cmd.grad_k]);
        if (i_cmd.do_t1) begin
            ma = 33'(r_v_old); mb = 33'(r_damp_in);
        end else if (i_cmd.do_t2) begin
            ma = r_hb; mb = 33'(r_grad);
        end else if (i_cmd.do_final) begin
            ma = 33'(r_damp_out); mb = 33'(r_inner);
        end
        prod = 66'(ma) * 66'(mb);
        prod_sh = prod >>> FRAC_BITS;
        s_val = sat(prod_sh[63:0], s_f);
    end

    logic signed [31:0] g_val, i_val;
    logic               g_f, i_f;
    always_comb begin
        g_val = sat(r_acc, g_f);
        i_val = sat(r_t1 - r_t2, i_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WIN; j++) r_win[j] <= '0;
            for (int j = 0; j < GHOST_DEPTH; j++) begin
                r_head[j] <= '0;
                r_tail[j] <= '0;
            end
            r_pts <= '0;
        end else begin
            if (i_cmd.load) begin
                r_win[0] <= i_p_lead;
                for (int j = 1; j < WIN; j++) r_win[j] <= r_win[j-1];
                r_v_old <= i_v_old;
                r_damp_in <= i_damp_in;
                r_damp_out <= i_damp_out;
                r_hb <= (33'(i_buoy_here) + 33'(i_buoy_next)) >>> 1;
                r_ovf <= 1'b0;
            end
            if (i_cmd.clr_acc) r_acc <= '0;
            else if (i_cmd.grad_step) r_acc <= r_acc + prod_sh[63:0];
            if (i_cmd.do_t1) begin
                r_grad <= g_val;
                r_ovf <= r_ovf | g_f;
                r_t1 <= prod_sh[63:0];
            end
            if (i_cmd.do_t2) r_t2 <= prod_sh[63:0];
            if (i_cmd.do_inner) begin
                r_inner <= i_val;
                r_ovf <= r_ovf | i_f;
            end
            if (i_cmd.do_final) begin
                r_ovf <= r_ovf | s_f;
                r_out <= s_val;
                r_out_ovf <= r_ovf | s_f;
            end
            if (i_cmd.ghost_sel) begin
                r_out <= i_cmd.ghost_right ? r_tail[i_cmd.ghost_off - 2'd1]
                                           : r_head[i_cmd.ghost_off - 2'd1];
                r_out_ovf <= 1'b0;
            end
            // head/tail entries and point count: clear at line end
            if (i_cmd.clr_line) begin
                r_pts <= '0;
                for (int j = 0; j < GHOST_DEPTH; j++) begin
                    r_head[j] <= '0;
                    r_tail[j] <= '0;
                end
            end else if (i_cmd.do_final) begin
                if (r_pts < 2'(GHOST_DEPTH)) r_head[r_pts] <= s_val;
                r_tail[0] <= s_val;
                for (int j = 1; j < GHOST_DEPTH; j++) r_tail[j] <= r_tail[j-1];
                if (r_pts != 2'd3) r_pts <= r_pts + 2'd1;
            end
        end
    end

    assign o_v   = r_out;
    assign o_ovf = r_out_ovf;
endmodule

/* design/svsu_ctrl.sv */
// Controller: sequences the stencil terms, products and result items.
module svsu_ctrl #(
    parameter int MAX_HALF_ORDER = svsu_pkg::MAX_HALF_ORDER_D
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_op,
    input  logic           i_line_last,
    input  logic [2:0]     i_h,
    input  logic           i_left,
    input  logic           i_right,
    output svsu_pkg::t_cmd o_cmd,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_kind,
    output logic [1:0]     o_off,
    output logic           o_last
);
    import svsu_pkg::*;
    t_state r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_ll, n_ll;
    logic       r_side, n_side;    // 0 left, 1 right
    logic [1:0] r_off, n_off;
    logic [1:0] r_kind, n_kind;
    logic [1:0] r_ooff, n_ooff;
    logic       r_last, n_last;
    logic [3:0] h_eff;
    logic [1:0] g;
    logic [2:0] nterm;

    always_comb begin
        h_eff = (i_h == 3'd0) ? 4'd1 :
                (4'(i_h) > 4'(MAX_HALF_ORDER)) ? 4'(MAX_HALF_ORDER) : 4'(i_h);
        g = (h_eff > 4'(GHOST_DEPTH)) ? 2'(GHOST_DEPTH) : 2'(h_eff - 4'd1);
        nterm = (h_eff > 4'(NUM_COEF)) ? 3'(NUM_COEF) : 3'(h_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k <= '0; r_ll <= 1'b0; r_side <= 1'b0; r_off <= '0;
            r_kind <= '0; r_ooff <= '0; r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k <= n_k; r_ll <= n_ll; r_side <= n_side; r_off <= n_off;
            r_kind <= n_kind; r_ooff <= n_ooff; r_last <= n_last;
        end
    end

    always_comb begin
        n_state = r_state; n_k = r_k; n_ll = r_ll; n_side = r_side; n_off = r_off;
        n_kind = r_kind; n_ooff = r_ooff; n_last = r_last;
        o_cmd = '0;
        o_cmd.grad_k = r_k;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.clr_acc = 1'b1;
                    n_ll = i_line_last;
                    n_k = '0;
                    if (i_op) n_state = ST_GRAD;
                end
            end
            ST_GRAD: begin
                o_cmd.grad_step = 1'b1;
                n_k = r_k + 2'd1;
                if (3'(r_k) + 3'd1 >= nterm) n_state = ST_T1;
            end
            ST_T1: begin o_cmd.do_t1 = 1'b1; n_state = ST_T2; end
            ST_T2: begin o_cmd.do_t2 = 1'b1; n_state = ST_INNER; end
            ST_INNER: begin o_cmd.do_inner = 1'b1; n_state = ST_FINAL; end
            ST_FINAL: begin
                o_cmd.do_final = 1'b1;
                n_kind = KIND_INTERIOR; n_ooff = '0;
                n_off = 2'd1;
                n_side = !(r_ll && i_left);
                n_last = !(r_ll && g != 2'd0 && (i_left || i_right));
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (r_last) begin
                        if (r_ll) o_cmd.clr_line = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_GHOST;
                    end
                end
            end
            ST_GHOST: begin
                // load next ghost item into the output register
                o_cmd.ghost_sel = 1'b1;
                o_cmd.ghost_right = r_side;
                o_cmd.ghost_off = r_off;
                n_kind = r_side ? KIND_RIGHT : KIND_LEFT;
                n_ooff = r_off;
                if (r_off == g) begin
                    n_off = 2'd1;
                    n_last = r_side || !i_right;
                    n_side = 1'b1;
                end else begin
                    n_off = r_off + 2'd1;
                    n_last = 1'b0;
                end
                n_state = ST_EMIT;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_kind = r_kind;
    assign o_off  = r_ooff;
    assign o_last = r_last;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("item taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_ghost_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_INTERIOR) |-> (o_off != 2'd0))
        else $error("ghost offset zero");
    a_clear_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_line |-> (o_valid && o_last)) else $error("early line clear");
`endif
endmodule

/* design/staggered_velocity_stencil_update_unit.sv */
// Top level of the staggered velocity stencil update unit.
// A computing item (op=1) steps through h stencil terms (h: half_order held to
// 1..MAX_HALF_ORDER, and to at most four terms), then the damping, buoyancy,
// inner and output steps, then its ghost items; a push-only item is only shifted
// in. The order is set by the single shared 33x33 multiplier, used once per
// stencil term and once each for the damping, buoyancy and output products, and
// by the one output register that ghost items pass through in turn.
module staggered_velocity_stencil_update_unit #(
    parameter int MAX_HALF_ORDER = svsu_pkg::MAX_HALF_ORDER_D,
    parameter int FRAC_BITS      = svsu_pkg::FRAC_BITS_D,
    parameter int DATA_WIDTH     = svsu_pkg::DATA_WIDTH_D
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic signed [31:0] i_p_lead,
    input  logic signed [31:0] i_v_old,
    input  logic signed [31:0] i_buoy_here,
    input  logic signed [31:0] i_buoy_next,
    input  logic signed [31:0] i_damp_in,
    input  logic signed [31:0] i_damp_out,
    input  logic               i_line_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_v_new,
    output logic [1:0]         o_kind,
    output logic [1:0]         o_ghost_offset,
    output logic               o_overflow,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import svsu_pkg::*;
    logic [2:0]         r_h;
    logic signed [31:0] r_coef [NUM_COEF];
    logic               r_left, r_right;
    t_cmd               cmd;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= 3'd1; r_left <= 1'b0; r_right <= 1'b0;
            for (int j = 0; j < NUM_COEF; j++) r_coef[j] <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HALF_ORDER) r_h <= i_cfg_data[2:0];
            else if (i_cfg_index >= REG_COEF_0 && i_cfg_index <= REG_COEF_3)
                r_coef[2'(i_cfg_index - REG_COEF_0)] <= i_cfg_data;
            else if (i_cfg_index == REG_LEFT_MIRROR) r_left <= i_cfg_data[0];
            else if (i_cfg_index == REG_RIGHT_MIRROR) r_right <= i_cfg_data[0];
        end
    end

    svsu_ctrl #(.MAX_HALF_ORDER(MAX_HALF_ORDER)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op, .i_line_last,
        .i_h(r_h), .i_left(r_left), .i_right(r_right), .o_cmd(cmd),
        .o_valid, .i_stall, .o_kind, .o_off(o_ghost_offset), .o_last
    );

    svsu_datapath #(.MAX_HALF_ORDER(MAX_HALF_ORDER), .FRAC_BITS(FRAC_BITS),
                    .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_h(r_h), .i_coef(r_coef), .i_p_lead,
        .i_v_old, .i_buoy_here, .i_buoy_next, .i_damp_in, .i_damp_out,
        .o_v(o_v_new), .o_ovf(o_overflow)
    );
endmodule

/* tb/staggered_velocity_stencil_update_unit_tb.sv */
// Self-checking testbench for the staggered velocity stencil update unit.
module staggered_velocity_stencil_update_unit_tb;
    import svsu_pkg::*;

    typedef struct packed {
        logic               op;
        logic signed [31:0] p_lead;
        logic signed [31:0] v_old;
        logic signed [31:0] buoy_here;
        logic signed [31:0] buoy_next;
        logic signed [31:0] damp_in;
        logic signed [31:0] damp_out;
        logic               line_last;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] v_new;
        logic [1:0]         kind;
        logic [1:0]         ghost_offset;
        logic               overflow;
        logic               last;
    } t_point_out;

    class velocity_scoreboard;
        logic signed [63:0] window [2*MAX_HALF_ORDER_D];
        logic signed [63:0] head [GHOST_DEPTH];
        logic signed [63:0] tail [GHOST_DEPTH];
        int unsigned        npoints;
        logic [2:0]         half_order;
        logic signed [63:0] coef [NUM_COEF];
        bit                 left_mirror, right_mirror;
        t_point_out         pending [$];
        int                 errors;

        function new();
            foreach (window[i]) window[i] = 0;
            foreach (head[i]) begin head[i] = 0; tail[i] = 0; end
            foreach (coef[i]) coef[i] = 0;
            npoints = 0; half_order = 1; left_mirror = 0; right_mirror = 0; errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            if (idx == REG_HALF_ORDER) half_order = data[2:0];
            else if (idx >= REG_COEF_0 && idx <= REG_COEF_3)
                coef[idx - REG_COEF_0] = $signed(data);
            else if (idx == REG_LEFT_MIRROR) left_mirror = data[0];
            else if (idx == REG_RIGHT_MIRROR) right_mirror = data[0];
        endfunction

        // floor shift: arithmetic right shift of a signed value already floors
        function logic signed [127:0] fsh(logic signed [127:0] x, int n);
            return x >>> n;
        endfunction

        function logic signed [127:0] sat(logic signed [127:0] x, ref bit ovf);
            if (x > 128'sd2147483647) begin ovf = 1; return 128'sd2147483647; end
            if (x < -128'sd2147483648) begin ovf = 1; return -128'sd2147483648; end
            return x;
        endfunction

        function void note_input(t_point_in it);
            int h, g;
            logic signed [127:0] acc, grad, hb, t1, t2, inner, v, d;
            bit ovf;
            t_point_out r;
            h = half_order;
            if (h < 1) h = 1;
            if (h > MAX_HALF_ORDER_D) h = MAX_HALF_ORDER_D;
            for (int i = 2*MAX_HALF_ORDER_D - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = it.p_lead;
            if (!it.op) return;
            acc = 0; ovf = 0;
            for (int k = 0; k < h && k < NUM_COEF; k++) begin
                d = window[h-k-1] - window[h+k];
                acc += fsh(coef[k] * d, FRAC_BITS_D);
            end
            grad = sat(acc, ovf);
            hb = fsh(128'(it.buoy_here) + 128'(it.buoy_next), 1);
            t1 = fsh(128'(it.v_old) * 128'(it.damp_in), FRAC_BITS_D);
            t2 = fsh(hb * grad, FRAC_BITS_D);
            inner = sat(t1 - t2, ovf);
            v = sat(fsh(128'(it.damp_out) * inner, FRAC_BITS_D), ovf);
            if (npoints < GHOST_DEPTH) head[npoints] = v;
            tail[2] = tail[1]; tail[1] = tail[0]; tail[0] = v;
            if (npoints < 3) npoints++;
            r = '{v_new: v[31:0], kind: KIND_INTERIOR, ghost_offset: 0,
                  overflow: ovf, last: 1'b0};
            pending.push_back(r);
            if (it.line_last) begin
                g = (h - 1 > GHOST_DEPTH) ? GHOST_DEPTH : h - 1;
                if (left_mirror)
                    for (int o = 1; o <= g; o++)
                        pending.push_back('{head[o-1][31:0], KIND_LEFT, 2'(o), 1'b0, 1'b0});
                if (right_mirror)
                    for (int o = 1; o <= g; o++)
                        pending.push_back('{tail[o-1][31:0], KIND_RIGHT, 2'(o), 1'b0, 1'b0});
                foreach (head[i]) begin head[i] = 0; tail[i] = 0; end
                npoints = 0;
            end
            pending[$].last = 1'b1;
        endfunction

        function void check_result(t_point_out got);
            t_point_out e;
            if (pending.size() == 0) begin
                $error("unexpected result v_new=%0d", got.v_new);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.v_new !== e.v_new) begin
                $error("v_new expected %0d actual %0d", e.v_new, got.v_new); errors++;
            end
            if (got.kind !== e.kind) begin
                $error("kind expected %0d actual %0d", e.kind, got.kind); errors++;
            end
            if (got.ghost_offset !== e.ghost_offset) begin
                $error("ghost_offset expected %0d actual %0d", e.ghost_offset,
                       got.ghost_offset); errors++;
            end
            if (got.overflow !== e.overflow) begin
                $error("overflow expected %0d actual %0d", e.overflow, got.overflow); errors++;
            end
            if (got.last !== e.last) begin
                $error("last expected %0d actual %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    t_point_in  drv;
    t_point_out mon;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    bit hold_off;

    velocity_scoreboard sb;

    staggered_velocity_stencil_update_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_op(drv.op), .i_p_lead(drv.p_lead), .i_v_old(drv.v_old),
        .i_buoy_here(drv.buoy_here), .i_buoy_next(drv.buoy_next),
        .i_damp_in(drv.damp_in), .i_damp_out(drv.damp_out),
        .i_line_last(drv.line_last),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_v_new(mon.v_new), .o_kind(mon.kind), .o_ghost_offset(mon.ghost_offset),
        .o_overflow(mon.overflow), .o_last(mon.last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    // result side: random stall per item, plus one long hold-off on request
    initial begin
        int gap;
        out_stall = 1;
        @(posedge clk iff rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (hold_off) begin
                out_stall <= 1;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            if (gap > 0) begin
                out_stall <= 1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk iff out_valid);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(mon);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
        @(posedge clk iff cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic send_point(t_point_in it, bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        drv <= it;
        @(posedge clk iff !in_stall);
        sb.note_input(it);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
            3: return $signed($urandom_range(0, 262143)) - 131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_point_in rnd_point(bit op, bit lst);
        t_point_in it;
        it.op = op; it.line_last = lst;
        it.p_lead = rnd_word(); it.v_old = rnd_word();
        it.buoy_here = rnd_word(); it.buoy_next = rnd_word();
        it.damp_in = rnd_word(); it.damp_out = rnd_word();
        return it;
    endfunction

    task automatic drain();
        in_valid <= 0;
        @(posedge clk iff sb.pending.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic config_all(logic [2:0] ho, bit lm, bit rm, bit extreme);
        write_reg(REG_HALF_ORDER, {29'd0, ho});
        for (int k = 0; k < NUM_COEF; k++)
            write_reg(REG_COEF_0 + 3'(k), extreme ? (k[0] ? 32'h80000000 : 32'h7fffffff)
                                                 : rnd_word());
        write_reg(REG_LEFT_MIRROR, {31'd0, lm});
        write_reg(REG_RIGHT_MIRROR, {31'd0, rm});
        cfg_valid <= 0;
    endtask

    initial begin
        t_point_in it;
        int len;
        sb = new();
        rst_n = 0; in_valid = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        drv = '0; hold_off = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: defaults, then extreme coefficients with both mirrors
        send_point('{1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'h7fffffff, 1'b1}, 0);
        drain();
        config_all(3'd4, 1, 1, 1);
        for (int i = 0; i < 8; i++) send_point(rnd_point(0, i[0]), 0);
        send_point('{1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h80000000, 1'b0}, 0);
        send_point(rnd_point(1, 0), 0);
        send_point(rnd_point(1, 0), 0);
        send_point(rnd_point(1, 0), 0);
        send_point(rnd_point(1, 1), 0);
        send_point(rnd_point(1, 1), 0);  // short line: ghosts past offset 1 read zero
        drain();
        config_all(3'd0, 1, 0, 0);
        send_point(rnd_point(1, 1), 0);
        drain();
        config_all(3'd7, 0, 1, 0);
        send_point(rnd_point(1, 0), 0);
        send_point(rnd_point(1, 1), 0);
        drain();

        // random phases of well-formed lines with occasional noise
        for (int ph = 0; ph < 6; ph++) begin
            config_all(3'($urandom_range(0, 7)), $urandom_range(0, 1),
                       $urandom_range(0, 1), ph == 5);
            if (ph == 2) hold_off = 1;
            for (int n = 0; n < 30; ) begin
                for (int w = $urandom_range(0, 4); w > 0; w--)
                    send_point(rnd_point(0, $urandom_range(0, 1)), ph == 2);
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++) begin
                    send_point(rnd_point(1, j == len - 1), ph == 2);
                    n++;
                end
            end
            drain();
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
